>>> sv/tbpc_pkg.sv
// Shared types and codes for the two-button press classifier.
package tbpc_pkg;

  // Result item codes
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_MODE_SHORT   = 3'd1,
    EV_MODE_LONG    = 3'd2,
    EV_POWER_SHORT  = 3'd3,
    EV_POWER_TOGGLE = 3'd4
  } event_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD     = 2'd1;

  localparam int unsigned CfgW  = 16;
  localparam int unsigned TimeW = 32;

  localparam logic [CfgW-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CfgW-1:0] HOLD_RESET     = 16'd5000;

  // Button tracking state carried between items
  typedef struct packed {
    logic             prev_power;
    logic             prev_mode;
    logic [TimeW-1:0] power_start;
    logic [TimeW-1:0] mode_start;
    logic             fired;
  } btn_state_t;

endpackage

>>> sv/two_button_press_classifier_unit.sv
// Top level of the two-button press classifier.
// Input channel: one item per tick carries the active-low levels of the
// power and mode buttons and a wrapping millisecond timestamp (now_ms).
// Output channel: exactly one result item per input item, event_res:
// none, mode short, mode long, power short or power toggle.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low.
// Structure: input register -> classifier logic -> result register.
// An accepted input item passes through the input register into the result
// register, where it is shown until it is taken; one item is taken every
// cycle while the result side keeps up. The button state is updated as an
// item passes into the result register, so back-to-back items see each
// other's effect.
// When the receiver stalls, the result holds; the input register still
// fills, and only once both stages hold an item does in_stall go high.
// Reset (rst, synchronous) empties both stages, releases both buttons,
// clears the press times and the fired flag, and loads debounce_ms = 50
// and hold_ms = 5000. cfg_wr_en writes cfg_data into the register chosen
// by cfg_index (0 debounce, 1 hold); other indexes are ignored. Write only
// while the block is idle.
module two_button_press_classifier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           power_level,
  input  logic                           mode_level,
  input  logic [tbpc_pkg::TimeW-1:0]     now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     event_res,
  input  logic                           cfg_wr_en,
  input  logic [tbpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tbpc_pkg::CfgW-1:0]      cfg_data
);
  import tbpc_pkg::*;

  // configuration registers
  logic [CfgW-1:0]  debounce_ms;
  logic [CfgW-1:0]  hold_ms;

  // input register stage
  logic             s1_valid;
  logic             s1_power;
  logic             s1_mode;
  logic [TimeW-1:0] s1_now;

  // button state and classifier outputs
  btn_state_t       st;
  btn_state_t       st_next;
  event_t           ev_next;
  event_t           ev;

  logic             out_take;   // result register can load this cycle
  logic             s1_move;    // item leaves input register
  logic             in_take;    // item accepted

  assign out_take = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_take;
  assign in_stall = s1_valid && !out_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      hold_ms     <= HOLD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_ms <= cfg_data;
        CFG_HOLD:     hold_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_power <= power_level;
      s1_mode  <= mode_level;
      s1_now   <= now_ms;
    end
  end

  tbpc_classify u_classify (
    .st          (st),
    .debounce_ms (debounce_ms),
    .hold_ms     (hold_ms),
    .power_level (s1_power),
    .mode_level  (s1_mode),
    .now_ms      (s1_now),
    .st_next     (st_next),
    .event_res   (ev_next)
  );

  // button state moves on only as an item is classified
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_power  <= 1'b1;
      st.prev_mode   <= 1'b1;
      st.power_start <= '0;
      st.mode_start  <= '0;
      st.fired       <= 1'b0;
    end else if (s1_move) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ev <= ev_next;
    end
  end

  assign event_res = ev;

endmodule

>>> sv/tbpc_classify.sv
// Combinational press classification: next button state and event code.
module tbpc_classify (
  input  tbpc_pkg::btn_state_t           st,
  input  logic [tbpc_pkg::CfgW-1:0]      debounce_ms,
  input  logic [tbpc_pkg::CfgW-1:0]      hold_ms,
  input  logic                           power_level,
  input  logic                           mode_level,
  input  logic [tbpc_pkg::TimeW-1:0]     now_ms,
  output tbpc_pkg::btn_state_t           st_next,
  output tbpc_pkg::event_t               event_res
);
  import tbpc_pkg::*;

  logic [TimeW-1:0] mode_held;
  logic [TimeW-1:0] power_held;
  logic [TimeW-1:0] deb_w;
  logic [TimeW-1:0] hold_w;
  logic             mode_press;
  logic             mode_rel;
  logic             mode_ev;
  logic             pwr_press;
  logic             pwr_rel;

  assign deb_w      = TimeW'(debounce_ms);
  assign hold_w     = TimeW'(hold_ms);
  assign mode_held  = now_ms - st.mode_start;
  assign power_held = now_ms - st.power_start;
  assign mode_press = !mode_level && st.prev_mode;
  assign mode_rel   = mode_level && !st.prev_mode;
  assign mode_ev    = mode_rel && (mode_held >= deb_w);
  assign pwr_press  = !power_level && st.prev_power;
  assign pwr_rel    = power_level && !st.prev_power;

  always_comb begin
    st_next           = st;
    event_res         = EV_NONE;
    st_next.prev_mode = mode_level;
    if (mode_press) begin
      st_next.mode_start = now_ms;
    end
    if (mode_ev) begin
      // power side is skipped entirely on a mode event
      event_res = (mode_held >= hold_w) ? EV_MODE_LONG : EV_MODE_SHORT;
    end else begin
      st_next.prev_power = power_level;
      if (pwr_press) begin
        st_next.power_start = now_ms;
        st_next.fired       = 1'b0;
      end else if (pwr_rel) begin
        if (power_held >= deb_w && !st.fired) begin
          if (power_held >= hold_w) begin
            st_next.fired = 1'b1;
            event_res     = EV_POWER_TOGGLE;
          end else begin
            event_res = EV_POWER_SHORT;
          end
        end
      end else if (!power_level && !st.fired && power_held >= hold_w) begin
        st_next.fired = 1'b1;
        event_res     = EV_POWER_TOGGLE;
      end
    end
  end

endmodule

>>> sv/tbpc_checker.sv
// Port-level checks for the two-button press classifier, bound to the top.
module tbpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] event_res
);
  import tbpc_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res))
    else $error("stalled result item changed");

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // input side only stalls when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result stage");

  // only defined event codes are shown
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res == EV_NONE || event_res == EV_MODE_SHORT ||
                   event_res == EV_MODE_LONG || event_res == EV_POWER_SHORT ||
                   event_res == EV_POWER_TOGGLE))
    else $error("undefined event code");

endmodule

bind two_button_press_classifier_unit tbpc_checker u_tbpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .event_res (event_res)
);
